// File: design/rdc_pkg.sv
// rdc_pkg: shared types and constants of the radix digit converter
// beat structs for both channels, controller to datapath command and status groups
// no dependencies
package rdc_pkg;

	localparam int DEF_VALUE_WIDTH = 64;
	localparam int FIELD_VALUE_W   = 64;
	localparam int BASE_W          = 17;
	localparam int DIGIT_W         = 16;
	localparam logic [BASE_W-1:0] BASE_MIN = 17'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 17'd65536;

	typedef struct packed {
		logic [FIELD_VALUE_W-1:0] value;
		logic [BASE_W-1:0]        base;
	} req_beat_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic               last;
	} rsp_beat_t;

	typedef struct packed {
		logic load;
		logic step;
		logic store;
		logic rd;
		logic show;
	} rdc_cmd_t;

	typedef struct packed {
		logic step_last;
		logic quot_zero;
		logic out_free;
		logic rd_first;
	} rdc_sts_t;

endpackage

// File: design/rdc_ram.sv
// rdc_ram: generic single write port, single read port memory with registered read
// no dependencies
module rdc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: design/rdc_ctrl.sv
// rdc_ctrl: sequencing state machine of the radix digit converter
// depends on rdc_pkg for the command and status structs
module rdc_ctrl
	import rdc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  rdc_sts_t sts,
	output rdc_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_STORE = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_SHOW  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (sts.step_last) begin
					state_d = ST_STORE;
				end
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				state_d   = sts.quot_zero ? ST_READ : ST_DIV;
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_SHOW;
			end
			ST_SHOW: begin
				if (sts.out_free) begin
					cmd.show = 1'b1;
					state_d  = sts.rd_first ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: design/rdc_dp.sv
// rdc_dp: datapath with bit-serial divider, digit store and output register
// depends on rdc_pkg and rdc_ram
module rdc_dp
	import rdc_pkg::*;
#(
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_beat_t req_beat,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp_beat,
	input  rdc_cmd_t  cmd,
	output rdc_sts_t  sts
);

	localparam int AW = $clog2(VALUE_WIDTH);

	logic [VALUE_WIDTH-1:0] dq_q;
	logic [BASE_W-1:0]      base_q;
	logic [BASE_W-1:0]      rem_q;
	logic [AW-1:0]          bit_q;
	logic [AW-1:0]          ndig_q;
	logic [AW-1:0]          rdidx_q;
	logic                   rsp_valid_q;
	rsp_beat_t              rsp_beat_q;

	logic [BASE_W:0]        trial;
	logic                   ge;
	logic [BASE_W:0]        diff;
	logic [BASE_W-1:0]      base_clamp;
	logic [DIGIT_W-1:0]     rd_data;

	assign trial = {rem_q, dq_q[VALUE_WIDTH-1]};
	assign ge    = (trial >= {1'b0, base_q});
	assign diff  = trial - {1'b0, base_q};

	always_comb begin
		base_clamp = req_beat.base;
		if (req_beat.base < BASE_MIN) begin
			base_clamp = BASE_MIN;
		end else if (req_beat.base > BASE_MAX) begin
			base_clamp = BASE_MAX;
		end
	end

	assign sts.step_last = (bit_q == AW'(VALUE_WIDTH - 1));
	assign sts.quot_zero = (dq_q == '0);
	assign sts.out_free  = !rsp_valid_q || !rsp_stall;
	assign sts.rd_first  = (rdidx_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dq_q   <= req_beat.value[VALUE_WIDTH-1:0];
			base_q <= base_clamp;
			rem_q  <= '0;
			bit_q  <= '0;
			ndig_q <= '0;
		end else if (cmd.step) begin
			dq_q  <= {dq_q[VALUE_WIDTH-2:0], ge};
			rem_q <= ge ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
			bit_q <= bit_q + AW'(1);
		end else if (cmd.store) begin
			rem_q   <= '0;
			bit_q   <= '0;
			ndig_q  <= ndig_q + AW'(1);
			rdidx_q <= ndig_q;
		end else if (cmd.show) begin
			rdidx_q <= rdidx_q - AW'(1);
		end
		if (cmd.show) begin
			rsp_beat_q.digit <= rd_data;
			rsp_beat_q.last  <= (rdidx_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.show) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	rdc_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (VALUE_WIDTH)
	) u_digits (
		.clk     (clk),
		.wr_en   (cmd.store),
		.wr_addr (ndig_q),
		.wr_data (rem_q[DIGIT_W-1:0]),
		.rd_en   (cmd.rd),
		.rd_addr (rdidx_q),
		.rd_data (rd_data)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp_beat  = rsp_beat_q;

endmodule

// File: design/radix_digit_converter_unit.sv
// radix_digit_converter_unit: top level of the radix digit converter
// depends on rdc_pkg, rdc_ctrl, rdc_dp and rdc_ram
//
// request channel: req_valid / req_stall / req_beat carries one value and a base
// (bases below 2 act as 2, above 65536 as 65536; value bits above VALUE_WIDTH ignored)
// response channel: rsp_valid / rsp_stall / rsp_beat gives the digits, most
// significant first, one per beat, last set on the units digit; a zero value
// gives a single zero digit
// digits are found least significant first by repeated division by the base in
// a one-bit-per-cycle divider, a divide pass over all value bits and then a store
// into a digit memory per digit, then read back in reverse, each beat a memory
// read and then a show into the output register
// req_stall is high from the beat after acceptance until the last digit sits in
// the output register
// when the receiver stalls the output register holds its beat and the readback
// waits; the divider of the next request may run beneath a pending last digit
// reset clears the sequencer and the output valid; no clearing pass is needed
module radix_digit_converter_unit
	import rdc_pkg::*;
#(
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_beat_t req_beat,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp_beat
);

	rdc_cmd_t cmd;
	rdc_sts_t sts;

	rdc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rdc_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_beat  (req_beat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_beat  (rsp_beat),
		.cmd       (cmd),
		.sts       (sts)
	);

`ifndef SYNTH
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while a conversion starts");

	a_busy_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_beat.last |-> req_stall)
		else $error("block idle before the last digit");

	a_show_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.show |-> (!rsp_valid || !rsp_stall))
		else $error("output register overwritten while stalled");
`endif

endmodule

// File: dv/radix_digit_converter_unit_test.sv
// radix_digit_converter_unit_test: self-checking bench for the radix digit converter,
// predicts the digit beats of every accepted request and checks them in order
// depends on rdc_pkg and radix_digit_converter_unit
module radix_digit_converter_unit_test
	import rdc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int VW = DEF_VALUE_WIDTH;
	localparam int RANDOM_REQS = 121;
	localparam int DRAIN_CYCLES = 4400;

	typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_BURSTY} stall_style_t;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_beat_t req_beat = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_beat_t rsp_beat;

	req_beat_t    req_backlog[$];
	rsp_beat_t    digits_due[$];
	rsp_beat_t    due;
	int unsigned  errors = 0;
	logic         req_fired = 1'b0;
	int unsigned  burst_left = 1;
	int unsigned  gap_left = 0;
	int unsigned  cycle_count = 0;
	int unsigned  style_left = 0;
	stall_style_t stall_style = STALL_NONE;

	radix_digit_converter_unit #(
		.VALUE_WIDTH(VW)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_beat (req_beat),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_beat (rsp_beat)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic void convert_to_digits(req_beat_t r);
		logic [63:0] v;
		logic [63:0] b;
		logic [63:0] p;
		logic [63:0] rem;
		rsp_beat_t   d;
		v = r.value & ({64{1'b1}} >> (64 - VW));
		b = 64'(r.base);
		if (b < 64'(BASE_MIN))
			b = 64'(BASE_MIN);
		if (b > 64'(BASE_MAX))
			b = 64'(BASE_MAX);
		p = 64'd1;
		while (p <= v / b)
			p = p * b;
		rem = v;
		while (1) begin
			d.digit = DIGIT_W'(rem / p);
			d.last  = (p == 64'd1);
			rem = rem % p;
			digits_due = {digits_due, d};
			if (d.last)
				break;
			p = p / b;
		end
	endfunction

	function automatic void queue_request(logic [63:0] v, logic [BASE_W-1:0] b);
		req_beat_t r;
		r.value = v;
		r.base  = b;
		req_backlog = {req_backlog, r};
	endfunction

	function automatic logic [BASE_W-1:0] pick_base();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 3)
			return BASE_W'($urandom_range(2, 16));
		else if (sel < 5)
			return BASE_W'(1) << $urandom_range(1, 16);
		else if (sel == 5)
			return $urandom_range(0, 1) ? BASE_W'($urandom_range(0, 1)) :
				BASE_W'($urandom_range(65537, 131071));
		else
			return BASE_W'($urandom_range(2, 65536));
	endfunction

	function automatic logic [63:0] pick_value();
		logic [63:0] v;
		int unsigned w;
		w = $urandom_range(0, 64);
		v = {$urandom(), $urandom()};
		if (w < 64)
			v = v & ((64'd1 << w) - 64'd1);
		return v;
	endfunction

	// request driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_fired)
				void'(req_backlog.pop_front());
			if (!req_valid || req_fired) begin
				if (gap_left > 0 || req_backlog.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					req_valid <= 1'b0;
				end else begin
					req_valid <= 1'b1;
					req_beat  <= req_backlog[0];
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 8);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
		end
	end

	// receiver stall pattern
	always @(negedge clk) begin
		cycle_count++;
		if (style_left == 0) begin
			stall_style = stall_style_t'($urandom_range(0, 2));
			style_left = $urandom_range(64, 512);
		end else begin
			style_left--;
		end
		case (stall_style)
			STALL_NONE: begin
				rsp_stall <= 1'b0;
			end
			STALL_RANDOM: begin
				rsp_stall <= ($urandom_range(0, 2) == 0);
			end
			default: begin
				rsp_stall <= (cycle_count % 16) < 11;
			end
		endcase
	end

	// monitor and checker
	always @(posedge clk) begin
		req_fired = arst_n && req_valid && !req_stall;
		if (req_fired)
			convert_to_digits(req_beat);
		if (arst_n && rsp_valid === 1'b1 && !rsp_stall) begin
			if (digits_due.size() == 0) begin
				$display("%0t unexpected beat: expected none, actual digit %h last %b",
					$realtime, rsp_beat.digit, rsp_beat.last);
				errors++;
			end else begin
				due = digits_due.pop_front();
				if (rsp_beat.digit !== due.digit) begin
					$display("%0t digit mismatch: expected %h, actual %h",
						$realtime, due.digit, rsp_beat.digit);
					errors++;
				end
				if (rsp_beat.last !== due.last) begin
					$display("%0t last mismatch: expected %b, actual %b",
						$realtime, due.last, rsp_beat.last);
					errors++;
				end
			end
		end
	end

	initial begin
		// zero, clamped bases, boundary values
		queue_request(64'd0, BASE_W'(10));
		queue_request(64'd0, BASE_W'(65536));
		queue_request(64'd0, BASE_W'(0));
		queue_request({64{1'b1}}, BASE_W'(2));
		queue_request({64{1'b1}}, BASE_W'(65536));
		queue_request({64{1'b1}}, BASE_W'(65535));
		queue_request({64{1'b1}}, BASE_W'(3));
		queue_request({64{1'b1}}, BASE_W'(0));
		queue_request(64'd5, BASE_W'(1));
		queue_request(64'h1234_5678_9abc_def0, BASE_W'(131071));
		queue_request(64'h1234_5678_9abc_def0, BASE_W'(65537));
		queue_request(64'd1, BASE_W'(2));
		queue_request(64'd10, BASE_W'(10));
		queue_request(64'd9, BASE_W'(10));
		queue_request(64'd10_000_000_000_000_000_000, BASE_W'(10));
		queue_request(64'h8000_0000_0000_0000, BASE_W'(2));
		queue_request(64'd65535, BASE_W'(65536));
		queue_request(64'd65536, BASE_W'(65536));
		queue_request(64'haaaa_5555_aaaa_5555, BASE_W'(16));
		for (int i = 0; i < RANDOM_REQS; i++)
			queue_request(pick_value(), pick_base());

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_backlog.size() != 0)
			@(posedge clk);
		while (digits_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && digits_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
